// File: rtl/mbrt_pkg.sv
// Package for the multicast block receive tracker.
// Transaction types, event classes, register indexes and size constants.
// No dependencies.
package mbrt_pkg;

	localparam int BLOCK_BYTES = 1024;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [10:0] SHORT_LEN = 11'(BLOCK_BYTES + 4);
	localparam logic [15:0] OP_DATA = 16'd3;
	localparam logic [15:0] OP_OACK = 16'd6;
	localparam logic [10:0] REPLY_MIN_LEN = 11'd2;

	typedef enum logic [1:0] {
		ACT_DATA    = 2'd0,
		ACT_REPLY   = 2'd1,
		ACT_TIMEOUT = 2'd2,
		ACT_UNUSED  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_RUNNING  = 2'd0,
		ST_FINISHED = 2'd1,
		ST_TIMEOUT  = 2'd2,
		ST_BADREPLY = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOTAL_BLOCKS = 2'd0,
		CFG_MAX_RETRIES  = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_DATA,
		KIND_REPLY_OK,
		KIND_REPLY_BAD,
		KIND_TIMEOUT
	} kind_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] opcode;
		logic [15:0] block_number;
		logic [10:0] payload_length;
		logic        master_flag;
	} evt_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        store_block;
		logic [25:0] store_offset;
		logic        send_request;
		logic [15:0] request_block;
		logic [15:0] loaded_count;
	} res_t;

	// classified event, front to back
	typedef struct packed {
		kind_t       kind;
		logic [15:0] blk;
		logic        blk_nz;
		logic        in_range;
		logic        short_pkt;
		logic [25:0] offset;
		logic        master_flag;
	} cmd_t;

endpackage

// File: rtl/multicast_block_receive_tracker.sv
// Top level of the multicast block receive tracker: configuration registers,
// front end, command queue and back end. Depends on mbrt_pkg, mbrt_front,
// mbrt_queue and mbrt_back.
//
//  channel  handshake          payload
//  evt      evt_valid/stall    evt (evt_t): action, opcode, block, length, flag
//  res      res_valid/stall    res (res_t): status, store, offset, request, count
//  cfg      cfg_valid/ready    cfg_index, cfg_data
//
// One event per cycle sustained while res_stall stays low; res_valid rises once an
// accepted event has passed the front register, the queue and the result register.
// The back end state update is combinational, so events never wait on each other.
// Reset clears all tracker state; total_blocks resets to 65535, max_retries to 3.
// A stall on res backs up into the two-entry queue before evt_stall rises.
// cfg_ready is always high.
module multicast_block_receive_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                evt_valid,
	output logic                                evt_stall,
	input  mbrt_pkg::evt_t                      evt,
	output logic                                res_valid,
	input  logic                                res_stall,
	output mbrt_pkg::res_t                      res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mbrt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbrt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mbrt_pkg::*;

	logic [15:0] total_blocks_q;
	logic [7:0]  max_retries_q;
	logic        q_full, q_push, q_empty, q_pop;
	cmd_t        q_wr_cmd, q_rd_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_blocks_q <= 16'hffff;
			max_retries_q <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_TOTAL_BLOCKS: total_blocks_q <= cfg_data[15:0];
				CFG_MAX_RETRIES: max_retries_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	mbrt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt_valid    (evt_valid),
		.evt_stall    (evt_stall),
		.evt          (evt),
		.total_blocks (total_blocks_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (q_wr_cmd)
	);

	mbrt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_wr_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rd_cmd (q_rd_cmd)
	);

	mbrt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.cmd         (q_rd_cmd),
		.max_retries (max_retries_q),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

endmodule

// File: rtl/mbrt_front.sv
// Front end: accepts event transactions, classifies them and precomputes
// the store offset. Depends on mbrt_pkg; feeds mbrt_queue.
module mbrt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	output logic              evt_stall,
	input  mbrt_pkg::evt_t    evt,
	input  logic [15:0]       total_blocks,
	input  logic              q_full,
	output logic              q_push,
	output mbrt_pkg::cmd_t    q_cmd
);
	import mbrt_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic take;

	always_comb begin
		cmd_d = '0;
		cmd_d.blk = evt.block_number;
		cmd_d.blk_nz = (evt.block_number != 16'd0);
		cmd_d.in_range = (evt.block_number <= total_blocks);
		cmd_d.short_pkt = (evt.payload_length < SHORT_LEN);
		cmd_d.offset = 26'(32'(evt.block_number - 16'd1) * BLOCK_BYTES);
		cmd_d.master_flag = evt.master_flag;
		unique case (action_t'(evt.action))
			ACT_DATA: begin
				cmd_d.kind = (evt.opcode == OP_DATA) ? KIND_DATA : KIND_NONE;
			end
			ACT_REPLY: begin
				if (evt.opcode != OP_OACK || evt.payload_length < REPLY_MIN_LEN)
					cmd_d.kind = KIND_REPLY_BAD;
				else
					cmd_d.kind = KIND_REPLY_OK;
			end
			ACT_TIMEOUT: cmd_d.kind = KIND_TIMEOUT;
			default: cmd_d.kind = KIND_NONE;
		endcase
	end

	assign evt_stall = valid_s1 & q_full;
	assign take = evt_valid & ~evt_stall;
	assign q_push = valid_s1 & ~q_full;
	assign q_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!evt_stall) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// File: rtl/mbrt_queue.sv
// Short command queue between front and back end.
// Depends on mbrt_pkg (cmd_t, QDEPTH).
module mbrt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mbrt_pkg::cmd_t    wr_cmd,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output mbrt_pkg::cmd_t    rd_cmd
);
	import mbrt_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign rd_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue pop while empty");

endmodule

// File: rtl/mbrt_back.sv
// Back end: applies classified events to the tracker state and registers
// one result transaction per event. Depends on mbrt_pkg; fed by mbrt_queue.
module mbrt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	output logic              q_pop,
	input  mbrt_pkg::cmd_t    cmd,
	input  logic [7:0]        max_retries,
	output logic              res_valid,
	input  logic              res_stall,
	output mbrt_pkg::res_t    res
);
	import mbrt_pkg::*;

	logic [15:0] prefix_end_q;
	logic [15:0] run_start_q;
	logic [15:0] run_end_q;
	logic [15:0] last_block_q;
	logic        last_seen_q;
	logic        master_mode_q;
	logic [7:0]  retry_count_q;
	logic [15:0] accepted_count_q;
	status_t     status_q;
	logic        res_valid_q;
	res_t        res_q;

	logic [15:0] n_prefix, n_rs, n_re, n_last, n_acc;
	logic        n_seen, n_master, used;
	logic [7:0]  n_retry;
	status_t     n_status;
	res_t        n_res;

	assign q_pop = ~q_empty & (~res_valid_q | ~res_stall);
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_comb begin
		n_prefix = prefix_end_q;
		n_rs = run_start_q;
		n_re = run_end_q;
		n_last = last_block_q;
		n_seen = last_seen_q;
		n_master = master_mode_q;
		n_retry = retry_count_q;
		n_acc = accepted_count_q;
		n_status = status_q;
		used = 1'b1;
		n_res = '0;
		if (status_q == ST_RUNNING) begin
			case (cmd.kind)
				KIND_DATA: begin
					if (cmd.short_pkt) begin
						n_last = cmd.blk;
						n_seen = 1'b1;
					end
					if (cmd.blk_nz) begin
						if ({1'b0, cmd.blk} == {1'b0, prefix_end_q} + 17'd1) begin
							n_prefix = cmd.blk;
							if ({1'b0, cmd.blk} + 17'd1 == {1'b0, run_start_q}) begin
								n_prefix = run_end_q;
								n_rs = '0;
								n_re = '0;
							end
						end else if ({1'b0, cmd.blk} == {1'b0, run_end_q} + 17'd1) begin
							n_re = cmd.blk;
						end else if (run_end_q == '0) begin
							n_rs = cmd.blk;
							n_re = cmd.blk;
						end else begin
							used = 1'b0;
						end
						if (used && cmd.in_range) begin
							n_acc = accepted_count_q + 16'd1;
							n_res.store_block = 1'b1;
							n_res.store_offset = cmd.offset;
						end
					end
					if (master_mode_q && n_seen && cmd.blk == n_last)
						n_status = ST_FINISHED;
				end
				KIND_REPLY_BAD: n_status = ST_BADREPLY;
				KIND_REPLY_OK: n_master = cmd.master_flag;
				KIND_TIMEOUT: begin
					if (retry_count_q < max_retries)
						n_retry = retry_count_q + 8'd1;
					else
						n_status = ST_TIMEOUT;
				end
				default: ;
			endcase
			if (n_status == ST_RUNNING && n_master) begin
				n_res.send_request = 1'b1;
				n_res.request_block = n_prefix;
			end
		end
		n_res.status = n_status;
		n_res.loaded_count = n_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_end_q <= '0;
			run_start_q <= '0;
			run_end_q <= '0;
			last_block_q <= '0;
			last_seen_q <= 1'b0;
			master_mode_q <= 1'b0;
			retry_count_q <= '0;
			accepted_count_q <= '0;
			status_q <= ST_RUNNING;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				prefix_end_q <= n_prefix;
				run_start_q <= n_rs;
				run_end_q <= n_re;
				last_block_q <= n_last;
				last_seen_q <= n_seen;
				master_mode_q <= n_master;
				retry_count_q <= n_retry;
				accepted_count_q <= n_acc;
				status_q <= n_status;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= n_res;
		end
	end

	a_status_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status_q != ST_RUNNING |=> status_q == $past(status_q))
		else $error("final status changed");
	a_store_live: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.store_block |->
		res_q.status == ST_RUNNING || res_q.status == ST_FINISHED)
		else $error("store reported after abort");
	a_req_running: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.send_request |-> res_q.status == ST_RUNNING && master_mode_q)
		else $error("request outside running master mode");

endmodule

// File: dv/mbrt_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the multicast block receive tracker testbench: predicts each
// result from the tracker state and checks the results that the block returns.
// Depends on mbrt_pkg.
package mbrt_tb_pkg;
	import mbrt_pkg::*;

	class tracker_scoreboard;
		logic [15:0] total_blocks;
		logic [7:0] max_retries;

		logic [15:0] prefix_end;
		logic [15:0] run_start;
		logic [15:0] run_end;
		logic [15:0] last_block;
		logic last_seen;
		logic master_mode;
		logic [7:0] retry_count;
		logic [15:0] accepted_count;
		status_t status;

		res_t pending_results[$];
		int unsigned mismatches;
		int unsigned results_checked;
		int unsigned stores_expected;
		int unsigned requests_expected;

		function new();
			total_blocks = 16'hFFFF;
			max_retries = 8'd3;
			prefix_end = '0;
			run_start = '0;
			run_end = '0;
			last_block = '0;
			last_seen = 1'b0;
			master_mode = 1'b0;
			retry_count = '0;
			accepted_count = '0;
			status = ST_RUNNING;
			mismatches = 0;
			results_checked = 0;
			stores_expected = 0;
			requests_expected = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [15:0] data);
			case (idx)
				CFG_TOTAL_BLOCKS: total_blocks = data;
				CFG_MAX_RETRIES: max_retries = data[7:0];
				default: ;
			endcase
		endfunction

		// one transaction through the tracker; state is kept only when commit is set
		function res_t advance_transfer(evt_t e, bit commit);
			logic [15:0] pe;
			logic [15:0] rs;
			logic [15:0] re;
			logic [15:0] lb;
			logic ls;
			logic mm;
			logic [7:0] rc;
			logic [15:0] ac;
			status_t st;
			logic used;
			logic [15:0] blk;
			res_t r;
			pe = prefix_end;
			rs = run_start;
			re = run_end;
			lb = last_block;
			ls = last_seen;
			mm = master_mode;
			rc = retry_count;
			ac = accepted_count;
			st = status;
			blk = e.block_number;
			r = '0;
			if (st == ST_RUNNING) begin
				case (e.action)
					ACT_DATA: if (e.opcode == OP_DATA) begin
						if (e.payload_length < SHORT_LEN) begin
							lb = blk;
							ls = 1'b1;
						end
						if (blk != 16'd0) begin
							used = 1'b1;
							if (17'(blk) == 17'(pe) + 17'd1) begin
								pe = blk;
								if (17'(pe) + 17'd1 == 17'(rs)) begin
									pe = re;
									rs = '0;
									re = '0;
								end
							end else if (17'(blk) == 17'(re) + 17'd1) begin
								re = blk;
							end else if (re == 16'd0) begin
								rs = blk;
								re = blk;
							end else begin
								used = 1'b0;
							end
							if (used && blk <= total_blocks) begin
								ac = ac + 16'd1;
								r.store_block = 1'b1;
								r.store_offset = 26'(blk - 16'd1) * 26'(BLOCK_BYTES);
							end
						end
						if (mm && ls && blk == lb)
							st = ST_FINISHED;
					end
					ACT_REPLY: begin
						if (e.opcode != OP_OACK || e.payload_length < REPLY_MIN_LEN)
							st = ST_BADREPLY;
						else
							mm = e.master_flag;
					end
					ACT_TIMEOUT: begin
						if (rc < max_retries)
							rc = rc + 8'd1;
						else
							st = ST_TIMEOUT;
					end
					default: ;
				endcase
				if (st == ST_RUNNING && mm) begin
					r.send_request = 1'b1;
					r.request_block = pe;
				end
			end
			r.status = st;
			r.loaded_count = ac;
			if (commit) begin
				prefix_end = pe;
				run_start = rs;
				run_end = re;
				last_block = lb;
				last_seen = ls;
				master_mode = mm;
				retry_count = rc;
				accepted_count = ac;
				status = st;
			end
			return r;
		endfunction

		function status_t status_after(evt_t e);
			res_t r;
			r = advance_transfer(e, 1'b0);
			return status_t'(r.status);
		endfunction

		function void note_event(evt_t e);
			res_t r;
			r = advance_transfer(e, 1'b1);
			if (r.store_block)
				stores_expected++;
			if (r.send_request)
				requests_expected++;
			pending_results.push_back(r);
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			if (mismatches <= 40)
				$display("%0t: %s mismatch at result %0d: got %0h, expected %0h",
					$time, what, results_checked, got, want);
		endtask

		task check_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", 32'(got.loaded_count), 32'd0);
				return;
			end
			want = pending_results.pop_front();
			results_checked++;
			if (got.status !== want.status)
				report_mismatch("status", 32'(got.status), 32'(want.status));
			if (got.store_block !== want.store_block)
				report_mismatch("store_block", 32'(got.store_block), 32'(want.store_block));
			if (got.store_offset !== want.store_offset)
				report_mismatch("store_offset", 32'(got.store_offset), 32'(want.store_offset));
			if (got.send_request !== want.send_request)
				report_mismatch("send_request", 32'(got.send_request), 32'(want.send_request));
			if (got.request_block !== want.request_block)
				report_mismatch("request_block", 32'(got.request_block), 32'(want.request_block));
			if (got.loaded_count !== want.loaded_count)
				report_mismatch("loaded_count", 32'(got.loaded_count), 32'(want.loaded_count));
		endtask
	endclass

endpackage

// File: dv/multicast_block_receive_tracker_tb.sv
`timescale 1ns / 100ps
// Testbench top for the multicast block receive tracker: directed and random
// packet, reply and timeout transactions with random gaps and stalls.
// Depends on mbrt_pkg, mbrt_tb_pkg and the tracker RTL.
module multicast_block_receive_tracker_tb;
	import mbrt_pkg::*;
	import mbrt_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 250000;
	localparam int PHASE_ITEMS = 230;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	evt_t evt = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tracker_scoreboard sb;
	int unsigned cycle_count = 0;
	int burst_left = 0;
	int unsigned events_sent = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned stall_span = 40;

	multicast_block_receive_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_span <= $urandom_range(20, 200);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			STALL_NONE: res_stall <= 1'b0;
			STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= cycle_count[1];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res);
	end

	function automatic evt_t make_event(action_t act, logic [15:0] op, logic [15:0] blk,
			logic [10:0] plen, logic flag);
		evt_t e;
		e.action = act;
		e.opcode = op;
		e.block_number = blk;
		e.payload_length = plen;
		e.master_flag = flag;
		return e;
	endfunction

	// mostly in-order blocks and near gaps; stray blocks only while a run exists
	function automatic logic [15:0] pick_block();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 45)
			return sb.prefix_end + 16'd1;
		if (sel < 65)
			return sb.run_end + 16'd1;
		if (sel < 78 || sb.run_end == 16'd0)
			return sb.prefix_end + 16'($urandom_range(2, 12));
		if (sel < 86)
			return 16'($urandom_range(0, sb.prefix_end));
		if (sel < 90)
			return 16'($urandom_range(65530, 65535));
		if (sel < 93)
			return 16'd0;
		return 16'($urandom);
	endfunction

	function automatic evt_t random_event();
		evt_t e;
		int unsigned sel;
		e = make_event(ACT_DATA, OP_DATA, pick_block(),
			11'($urandom_range(BLOCK_BYTES + 4, 2047)), 1'($urandom));
		sel = $urandom_range(0, 99);
		if (sel < 12) begin
			e.payload_length = 11'($urandom_range(0, BLOCK_BYTES + 3));
		end else if (sel < 20) begin
			e.opcode = 16'($urandom);
		end else if (sel < 28) begin
			e.action = ACT_REPLY;
			e.opcode = ($urandom_range(0, 9) == 0) ? 16'($urandom) : OP_OACK;
			e.payload_length = 11'($urandom_range(0, 2047));
		end else if (sel < 35) begin
			e.action = ACT_TIMEOUT;
			e.opcode = 16'($urandom);
		end else if (sel < 40) begin
			e.action = ACT_UNUSED;
			e.opcode = 16'($urandom);
			e.block_number = 16'($urandom);
			e.payload_length = 11'($urandom);
		end
		return e;
	endfunction

	task automatic send_event(input evt_t e);
		if (burst_left == 0) begin
			evt_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		evt <= e;
		evt_valid <= 1'b1;
		do @(posedge clk); while (!(evt_valid && !evt_stall));
		sb.note_event(e);
		events_sent++;
		burst_left--;
	endtask

	// keep the transfer running unless the ending is wanted
	task automatic send_random(input bit allow_end);
		evt_t e;
		do e = random_event(); while (!allow_end && sb.status_after(e) != ST_RUNNING);
		send_event(e);
	endtask

	task automatic drain();
		evt_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic configure(input logic [15:0] total, input logic [7:0] retries);
		cfg_index <= CFG_TOTAL_BLOCKS;
		cfg_data <= total;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.set_register(CFG_TOTAL_BLOCKS, total);
		cfg_index <= CFG_MAX_RETRIES;
		cfg_data <= 16'(retries);
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.set_register(CFG_MAX_RETRIES, 16'(retries));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [15:0] total, input logic [7:0] retries);
		drain();
		configure(total, retries);
		repeat (PHASE_ITEMS) send_random(1'b0);
	endtask

	task automatic directed_events();
		send_event(make_event(ACT_DATA, OP_DATA, 16'd0, 11'd1028, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd1, 11'd1028, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd3, 11'd1028, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd1, 11'd1028, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'hFFFF, 11'd0, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd6, 11'd1028, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd4, 11'd1028, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd2, 11'd1028, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd5, 11'd2047, 1'b0));
		send_event(make_event(ACT_DATA, 16'hFFFF, 16'd6, 11'd1028, 1'b1));
		send_event(make_event(ACT_DATA, 16'h0000, 16'd7, 11'd0, 1'b0));
		send_event(make_event(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 11'h7FF, 1'b1));
		send_event(make_event(ACT_TIMEOUT, 16'd0, 16'd0, 11'd0, 1'b0));
		send_event(make_event(ACT_REPLY, OP_OACK, 16'd0, REPLY_MIN_LEN, 1'b1));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd6, 11'd1028, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd0, 11'd2047, 1'b0));
		send_event(make_event(ACT_TIMEOUT, 16'hFFFF, 16'hFFFF, 11'h7FF, 1'b1));
		send_event(make_event(ACT_REPLY, OP_OACK, 16'd0, 11'd2047, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd7, 11'd1027, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd9, 11'd1028, 1'b0));
		send_event(make_event(ACT_UNUSED, 16'd0, 16'd0, 11'd0, 1'b1));
	endtask

	// close a run ahead of the prefix, open one behind it, then end the transfer
	task automatic end_transfer();
		logic [15:0] op;
		send_event(make_event(ACT_REPLY, OP_OACK, 16'd0, 11'd100, 1'b0));
		while (sb.run_end != 16'd0 && sb.run_start > sb.prefix_end)
			send_event(make_event(ACT_DATA, OP_DATA, sb.prefix_end + 16'd1, 11'd1500, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd1, 11'd1028, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'd2, 11'd1028, 1'b0));
		send_event(make_event(ACT_DATA, OP_DATA, 16'hFFFF, 11'd1028, 1'b0));
		case ($urandom_range(0, 2))
			0: begin
				send_event(make_event(ACT_REPLY, OP_OACK, 16'd0, REPLY_MIN_LEN, 1'b1));
				send_event(make_event(ACT_DATA, OP_DATA, 16'($urandom), 11'd600, 1'b0));
			end
			1: begin
				while (sb.status == ST_RUNNING)
					send_event(make_event(ACT_TIMEOUT, 16'd0, 16'd0, 11'd0, 1'b0));
			end
			default: begin
				op = 16'($urandom);
				if (op == OP_OACK)
					send_event(make_event(ACT_REPLY, op, 16'd0, 11'($urandom_range(0, 1)), 1'b1));
				else
					send_event(make_event(ACT_REPLY, op, 16'd0, 11'd512, 1'b1));
			end
		endcase
		repeat (12) send_random(1'b1);
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		configure(16'd4, 8'd3);
		directed_events();
		run_phase(16'hFFFF, 8'd3);
		run_phase(16'd1, 8'd255);
		run_phase(16'($urandom_range(2, 400)), 8'd0);
		run_phase(16'($urandom_range(2, 65534)), 8'($urandom_range(1, 254)));
		run_phase(16'hFFFF, 8'd255);
		end_transfer();
		drain();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch("missing transactions", sb.pending(), 32'd0);
		$display("Sent %0d events with %0d expected stores and %0d master requests; %0d results checked.",
			events_sent, sb.stores_expected, sb.requests_expected, sb.results_checked);
		$display("Transfer ended as %s with %0d blocks loaded, %0d mismatches.",
			sb.status.name(), sb.accepted_count, sb.mismatches);
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("Cycle limit reached with %0d results outstanding.", sb.pending());
		$display("FAIL");
		$finish;
	end

endmodule
